// ===== sv/sui_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial unit-interval calibrator package
// Widths, codes, marker-interval and bound tables shared by the block.
// ----------------------------------------------------------------------------
package sui_pkg;

  localparam int TIME_W       = 46;
  localparam int COUNT_IN_W   = 15;
  localparam int COUNT_WIDTH  = 15;
  localparam int IV_W         = 26;
  localparam int UI_SHIFT     = 12;
  localparam int DIVIDEND_W   = TIME_W + UI_SHIFT;
  localparam int UI_W         = 32;
  localparam int STATUS_W     = 4;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 5;
  localparam int RATE_W       = 3;
  localparam int FEC_W        = 2;
  localparam int SPEED_W      = 2;
  localparam int LANES_W      = 5;

  localparam logic [TIME_W-1:0] ONE_SECOND = 46'h3B9ACA000000;

  localparam logic [UI_W-1:0] UI10_MIN = 32'h018CC73E;
  localparam logic [UI_W-1:0] UI10_MAX = 32'h018D98F5;
  localparam logic [UI_W-1:0] UI25_MIN = 32'h009EDC00;
  localparam logic [UI_W-1:0] UI25_MAX = 32'h009EE420;

  localparam logic [IV_W-1:0] AM_5406720  = 26'd5406720;
  localparam logic [IV_W-1:0] AM_168960   = 26'd168960;
  localparam logic [IV_W-1:0] AM_4325376  = 26'd4325376;
  localparam logic [IV_W-1:0] AM_21626880 = 26'd21626880;
  localparam logic [IV_W-1:0] AM_43253760 = 26'd43253760;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_RATE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FEC   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LANES = 2'd3;

  // rate, FEC and speed codes
  localparam logic [RATE_W-1:0] RATE_10_25  = 3'd0;
  localparam logic [RATE_W-1:0] RATE_50     = 3'd1;
  localparam logic [RATE_W-1:0] RATE_40_100 = 3'd2;
  localparam logic [RATE_W-1:0] RATE_200    = 3'd3;
  localparam logic [RATE_W-1:0] RATE_400    = 3'd4;
  localparam logic [FEC_W-1:0]  FEC_KR      = 2'd0;
  localparam logic [FEC_W-1:0]  FEC_NONE    = 2'd1;
  localparam logic [SPEED_W-1:0] SPEED_10G  = 2'd0;
  localparam logic [SPEED_W-1:0] SPEED_25G  = 2'd1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_STORED        = 4'd0;
  localparam logic [STATUS_W-1:0] ST_FIRST_INVALID = 4'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FIRST      = 4'd2;
  localparam logic [STATUS_W-1:0] ST_LATE          = 4'd3;
  localparam logic [STATUS_W-1:0] ST_LATER_INVALID = 4'd4;
  localparam logic [STATUS_W-1:0] ST_NO_INTERVAL   = 4'd5;
  localparam logic [STATUS_W-1:0] ST_TX_RANGE      = 4'd6;
  localparam logic [STATUS_W-1:0] ST_RX_RANGE      = 4'd7;
  localparam logic [STATUS_W-1:0] ST_UPDATED       = 4'd8;

  typedef struct packed {
    logic [IV_W-1:0] tx;
    logic [IV_W-1:0] rx;
  } iv_pair_t;

  typedef struct packed {
    logic [UI_W-1:0] lo;
    logic [UI_W-1:0] hi;
  } bounds_t;

  typedef struct packed {
    logic                  zero;
    logic [DIVIDEND_W-1:0] ui;
  } path_res_t;

  function automatic iv_pair_t pick_intervals(logic [RATE_W-1:0] rate,
                                              logic [FEC_W-1:0] fec);
    iv_pair_t p;
    p = '0;
    unique case (rate)
      RATE_10_25: begin
        if (fec == FEC_KR) begin
          p.tx = AM_5406720;
          p.rx = AM_5406720;
        end else if (fec == FEC_NONE) begin
          p.tx = AM_5406720;
          p.rx = AM_168960;
        end
      end
      RATE_50: begin
        if (fec == FEC_NONE) begin
          p.tx = AM_4325376;
          p.rx = AM_4325376;
        end else begin
          p.tx = AM_5406720;
          p.rx = AM_5406720;
        end
      end
      RATE_40_100, RATE_200: begin
        p.tx = AM_21626880;
        p.rx = AM_21626880;
      end
      RATE_400: begin
        p.tx = AM_43253760;
        p.rx = AM_43253760;
      end
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic bounds_t pick_bounds(logic [SPEED_W-1:0] speed);
    bounds_t b;
    unique case (speed)
      SPEED_10G: begin
        b.lo = UI10_MIN;
        b.hi = UI10_MAX;
      end
      SPEED_25G: begin
        b.lo = UI25_MIN;
        b.hi = UI25_MAX;
      end
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/sui_if.sv =====
// ----------------------------------------------------------------------------
// Serial unit-interval calibrator channels
// Snapshot channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface sui_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [sui_pkg::TIME_W-1:0]     tx_time;
  logic [sui_pkg::COUNT_IN_W-1:0] tx_count;
  logic                           tx_valid;
  logic [sui_pkg::TIME_W-1:0]     rx_time;
  logic [sui_pkg::COUNT_IN_W-1:0] rx_count;
  logic                           rx_valid;
  logic                           too_late;

  modport source(output valid, func, tx_time, tx_count, tx_valid, rx_time, rx_count,
                 rx_valid, too_late, input ready);
  modport sink(input valid, func, tx_time, tx_count, tx_valid, rx_time, rx_count,
               rx_valid, too_late, output ready);
endinterface

interface sui_out_if;
  logic                         valid;
  logic                         ready;
  logic [sui_pkg::STATUS_W-1:0] status;
  logic [sui_pkg::UI_W-1:0]     tx_unit_interval;
  logic [sui_pkg::UI_W-1:0]     rx_unit_interval;
  logic                         write_enable;

  modport source(output valid, status, tx_unit_interval, rx_unit_interval, write_enable,
                 input ready);
  modport sink(input valid, status, tx_unit_interval, rx_unit_interval, write_enable,
               output ready);
endinterface

// ===== sv/sui_mul.sv =====
// ----------------------------------------------------------------------------
// Serial shift-add multiplier
// One multiplier bit per cycle, LSB first; product valid with done.
// ----------------------------------------------------------------------------
module sui_mul #(
  parameter int A_W = 16,
  parameter int B_W = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [A_W-1:0]   a,
  input  logic [B_W-1:0]   b,
  output logic             done,
  output logic [A_W+B_W-1:0] product
);
  localparam int CNT_W = $clog2(A_W + 1);

  logic [A_W+B_W-1:0] p;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [B_W:0]       sum;

  assign sum     = {1'b0, p[A_W+B_W-1:A_W]} + (p[0] ? {1'b0, b} : '0);
  assign product = p;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(A_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p <= {{B_W{1'b0}}, a};
    end else if (busy) begin
      p <= {sum, p[A_W-1:1]};
    end
  end
endmodule

// ===== sv/sui_div.sv =====
// ----------------------------------------------------------------------------
// Serial restoring divider
// One quotient bit per cycle, MSB first; quotient valid with done.
// ----------------------------------------------------------------------------
module sui_div #(
  parameter int N = 58,
  parameter int D = 42
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);
  localparam int CNT_W = $clog2(N + 1);

  logic [D-1:0]     rem;
  logic [N-1:0]     quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [D:0]       trial;
  logic [D:0]       diff;
  logic             ge;

  assign trial    = {rem, quo[N-1]};
  assign ge       = trial >= {1'b0, divisor};
  assign diff     = trial - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[D-1:0] : trial[D-1:0];
      quo <= {quo[N-2:0], ge};
    end
  end
endmodule

// ===== sv/sui_path.sv =====
// ----------------------------------------------------------------------------
// Unit-interval path
// Count delta times marker interval, divide by lanes, then divide the
// shifted time delta by that divisor.
// ----------------------------------------------------------------------------
module sui_path #(
  parameter int COUNT_WIDTH = sui_pkg::COUNT_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sui_pkg::TIME_W-1:0]   dt,
  input  logic [COUNT_WIDTH:0]         dc,
  input  logic [sui_pkg::IV_W-1:0]     iv,
  input  logic [sui_pkg::LANES_W-1:0]  lanes,
  output logic                         done,
  output sui_pkg::path_res_t           res
);
  localparam int DC_W = COUNT_WIDTH + 1;
  localparam int PW   = DC_W + sui_pkg::IV_W;
  localparam int DVD_W = sui_pkg::DIVIDEND_W;

  logic             mul_done;
  logic [PW-1:0]    prod;
  logic             ldiv_done;
  logic [PW-1:0]    divisor;
  logic             ldiv_zero;
  logic             udiv_done;
  logic [DVD_W-1:0] ui;

  sui_mul #(.A_W(DC_W), .B_W(sui_pkg::IV_W)) u_mul (
    .clk(clk), .rst(rst), .start(start), .a(dc), .b(iv),
    .done(mul_done), .product(prod)
  );

  sui_div #(.N(PW), .D(sui_pkg::LANES_W)) u_ldiv (
    .clk(clk), .rst(rst), .start(mul_done), .dividend(prod), .divisor(lanes),
    .done(ldiv_done), .quotient(divisor)
  );

  assign ldiv_zero = (divisor == '0);

  sui_div #(.N(DVD_W), .D(PW)) u_udiv (
    .clk(clk), .rst(rst), .start(ldiv_done && !ldiv_zero),
    .dividend({dt, {sui_pkg::UI_SHIFT{1'b0}}}), .divisor(divisor),
    .done(udiv_done), .quotient(ui)
  );

  // a zero divisor finishes right after the lane division
  assign done     = udiv_done || (ldiv_done && ldiv_zero);
  assign res.zero = ldiv_done && ldiv_zero;
  assign res.ui   = ui;
endmodule

// ===== sv/serial_unit_interval_calibrator.sv =====
// ----------------------------------------------------------------------------
// Serial unit-interval calibrator
// Pairs marker snapshots and computes TX and RX unit intervals in 4.28 ns.
// ----------------------------------------------------------------------------
// Usage:
//   snap   : one beat per snapshot (func 0 stores, func 1 pairs with the
//            stored one). One beat on result answers every snapshot beat.
//   result : status, both unit intervals and write_enable; intervals are
//            zero unless status is "updated".
//   cfg    : write rate_mode, fec_mode, link_speed_mode, lanes_used by index
//            while no snapshot is in flight.
// Answers: snapshots that need no arithmetic answer in the cycle after accept.
//   A pairing that computes intervals runs the TX and RX paths side by side:
//   a shift-add multiply, a lane divide and a time divide, plus handoff
//   registers, and result.valid rises once both paths are done.
// Throughput: one snapshot at a time; the serial units set the rate.
// Reset: clears the stored snapshot flag, the config (lanes_used to 1) and
//   the result channel. A stalled result holds its beat; snap.ready stays
//   low until the result is taken or is being taken.
// ----------------------------------------------------------------------------
module serial_unit_interval_calibrator #(
  parameter int COUNT_WIDTH = sui_pkg::COUNT_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  sui_in_if.sink                           snap,
  sui_out_if.source                        result,
  input  logic                             cfg_write,
  input  logic [sui_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sui_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam int CW = COUNT_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state;

  // configuration
  logic [sui_pkg::RATE_W-1:0]  rate_mode;
  logic [sui_pkg::FEC_W-1:0]   fec_mode;
  logic [sui_pkg::SPEED_W-1:0] link_speed_mode;
  logic [sui_pkg::LANES_W-1:0] lanes_used;

  // stored first snapshot
  logic [sui_pkg::TIME_W-1:0] first_tx_time;
  logic [sui_pkg::TIME_W-1:0] first_rx_time;
  logic [CW-1:0]              first_tx_count;
  logic [CW-1:0]              first_rx_count;
  logic                       have_first;

  // operands held for the paths
  logic [sui_pkg::TIME_W-1:0] tx_dt, rx_dt;
  logic [CW:0]                tx_dc, rx_dc;
  logic [sui_pkg::IV_W-1:0]   tx_iv, rx_iv;
  logic                       go;

  // path results
  logic               tx_done, rx_done;
  sui_pkg::path_res_t tx_res, rx_res;
  logic               tx_fin, rx_fin;
  sui_pkg::path_res_t tx_hold, rx_hold;

  logic accept;
  logic out_free;
  logic [CW-1:0] tx_cnow, rx_cnow;
  logic [sui_pkg::TIME_W-1:0] tx_dt_next, rx_dt_next;
  logic [CW:0] tx_dc_next, rx_dc_next;
  sui_pkg::iv_pair_t ivs;
  sui_pkg::bounds_t  bnd;
  logic [sui_pkg::STATUS_W-1:0] fin_status;

  assign out_free   = !result.valid || result.ready;
  assign snap.ready = (state == S_IDLE) && out_free;
  assign accept     = snap.valid && snap.ready;

  // time delta wraps at one second, an equal value counts as a full wrap
  assign tx_dt_next = snap.tx_time - first_tx_time
                      + ((snap.tx_time <= first_tx_time) ? sui_pkg::ONE_SECOND : '0);
  assign rx_dt_next = snap.rx_time - first_rx_time
                      + ((snap.rx_time <= first_rx_time) ? sui_pkg::ONE_SECOND : '0);

  // count delta in 1 .. 2^CW
  assign tx_cnow    = CW'(snap.tx_count);
  assign rx_cnow    = CW'(snap.rx_count);
  assign tx_dc_next = (tx_cnow == first_tx_count) ? {1'b1, {CW{1'b0}}}
                                                  : {1'b0, tx_cnow - first_tx_count};
  assign rx_dc_next = (rx_cnow == first_rx_count) ? {1'b1, {CW{1'b0}}}
                                                  : {1'b0, rx_cnow - first_rx_count};

  assign ivs = sui_pkg::pick_intervals(rate_mode, fec_mode);
  assign bnd = sui_pkg::pick_bounds(link_speed_mode);

  sui_path #(.COUNT_WIDTH(CW)) u_tx (
    .clk(clk), .rst(rst), .start(go), .dt(tx_dt), .dc(tx_dc), .iv(tx_iv),
    .lanes(lanes_used), .done(tx_done), .res(tx_res)
  );

  sui_path #(.COUNT_WIDTH(CW)) u_rx (
    .clk(clk), .rst(rst), .start(go), .dt(rx_dt), .dc(rx_dc), .iv(rx_iv),
    .lanes(lanes_used), .done(rx_done), .res(rx_res)
  );

  // status once both paths are in; the range check sees the full quotient
  always_comb begin
    priority if (tx_hold.zero || rx_hold.zero) begin
      fin_status = sui_pkg::ST_NO_INTERVAL;
    end else if (tx_hold.ui > sui_pkg::DIVIDEND_W'(bnd.hi)
                 || tx_hold.ui < sui_pkg::DIVIDEND_W'(bnd.lo)) begin
      fin_status = sui_pkg::ST_TX_RANGE;
    end else if (rx_hold.ui > sui_pkg::DIVIDEND_W'(bnd.hi)
                 || rx_hold.ui < sui_pkg::DIVIDEND_W'(bnd.lo)) begin
      fin_status = sui_pkg::ST_RX_RANGE;
    end else begin
      fin_status = sui_pkg::ST_UPDATED;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_mode       <= '0;
      fec_mode        <= '0;
      link_speed_mode <= '0;
      lanes_used      <= sui_pkg::LANES_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        sui_pkg::CFG_RATE:  rate_mode       <= cfg_data[sui_pkg::RATE_W-1:0];
        sui_pkg::CFG_FEC:   fec_mode        <= cfg_data[sui_pkg::FEC_W-1:0];
        sui_pkg::CFG_SPEED: link_speed_mode <= cfg_data[sui_pkg::SPEED_W-1:0];
        sui_pkg::CFG_LANES: lanes_used      <= cfg_data[sui_pkg::LANES_W-1:0];
        default: ;
      endcase
    end
  end

  // control: snapshot handling, sequencing and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      have_first   <= 1'b0;
      go           <= 1'b0;
      tx_fin       <= 1'b0;
      rx_fin       <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      go <= 1'b0;
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end

      if (tx_done) begin
        tx_fin <= 1'b1;
      end
      if (rx_done) begin
        rx_fin <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            // every answer without arithmetic goes out now
            result.valid <= 1'b1;
            if (!snap.func) begin
              have_first    <= snap.tx_valid && snap.rx_valid;
              result.status <= (snap.tx_valid && snap.rx_valid) ? sui_pkg::ST_STORED
                                                              : sui_pkg::ST_FIRST_INVALID;
            end else if (!have_first) begin
              result.status <= sui_pkg::ST_NO_FIRST;
            end else begin
              // pairing consumes the stored snapshot whatever the outcome
              have_first <= 1'b0;
              priority if (snap.too_late) begin
                result.status <= sui_pkg::ST_LATE;
              end else if (!snap.tx_valid || !snap.rx_valid) begin
                result.status <= sui_pkg::ST_LATER_INVALID;
              end else if (ivs.tx == '0 || ivs.rx == '0 || lanes_used == '0) begin
                result.status <= sui_pkg::ST_NO_INTERVAL;
              end else begin
                // hold the result back and start both paths
                result.valid <= 1'b0;
                go           <= 1'b1;
                state        <= S_RUN;
              end
            end
          end
        end
        S_RUN: begin
          if (tx_fin && rx_fin) begin
            tx_fin        <= 1'b0;
            rx_fin        <= 1'b0;
            result.valid  <= 1'b1;
            result.status <= fin_status;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      result.tx_unit_interval <= '0;
      result.rx_unit_interval <= '0;
      result.write_enable     <= 1'b0;
      if (!snap.func && snap.tx_valid && snap.rx_valid) begin
        first_tx_time  <= snap.tx_time;
        first_rx_time  <= snap.rx_time;
        first_tx_count <= tx_cnow;
        first_rx_count <= rx_cnow;
      end
      tx_dt <= tx_dt_next;
      rx_dt <= rx_dt_next;
      tx_dc <= tx_dc_next;
      rx_dc <= rx_dc_next;
      tx_iv <= ivs.tx;
      rx_iv <= ivs.rx;
    end
    if (tx_done) begin
      tx_hold <= tx_res;
    end
    if (rx_done) begin
      rx_hold <= rx_res;
    end
    if (state == S_RUN && tx_fin && rx_fin) begin
      result.write_enable <= (fin_status == sui_pkg::ST_UPDATED);
      result.tx_unit_interval <= (fin_status == sui_pkg::ST_UPDATED)
                                 ? tx_hold.ui[sui_pkg::UI_W-1:0] : '0;
      result.rx_unit_interval <= (fin_status == sui_pkg::ST_UPDATED)
                                 ? rx_hold.ui[sui_pkg::UI_W-1:0] : '0;
    end
  end

  // write_enable follows the status exactly
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.write_enable == (result.status == sui_pkg::ST_UPDATED)))
    else $error("write_enable disagrees with status");

  // intervals are zero unless the pairing updated
  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.write_enable
      |-> (result.tx_unit_interval == '0 && result.rx_unit_interval == '0))
    else $error("nonzero interval on a result that is not an update");

  // a pairing snapshot always consumes the stored one
  assert property (@(posedge clk) disable iff (rst)
    accept && snap.func |=> !have_first)
    else $error("stored snapshot survived a pairing");

  // no new snapshot while the paths compute
  assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> !snap.ready)
    else $error("snapshot accepted during computation");
endmodule

// ===== tb/sv/tb_serial_unit_interval_calibrator.sv =====
// ----------------------------------------------------------------------------
// Unit-interval calibrator testbench
// Drives snapshot beats through a directed table and then random pairing
// sequences. An in-bench calibrator model predicts every result beat, and
// each taken result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_serial_unit_interval_calibrator;

  localparam int DC_W = sui_pkg::COUNT_WIDTH + 1;

  // One snapshot beat as the sender presents it.
  typedef struct {
    logic                           func;
    logic [sui_pkg::TIME_W-1:0]     tx_time;
    logic [sui_pkg::COUNT_IN_W-1:0] tx_count;
    logic                           tx_valid;
    logic [sui_pkg::TIME_W-1:0]     rx_time;
    logic [sui_pkg::COUNT_IN_W-1:0] rx_count;
    logic                           rx_valid;
    logic                           too_late;
  } snap_t;

  // One result beat.
  typedef struct {
    logic [sui_pkg::STATUS_W-1:0] status;
    logic [sui_pkg::UI_W-1:0]     tx_ui;
    logic [sui_pkg::UI_W-1:0]     rx_ui;
    logic                         wr_en;
  } calib_t;

  // Row of the directed table; check_code set means the status is typed in.
  typedef struct {
    snap_t                        s;
    logic                         check_code;
    logic [sui_pkg::STATUS_W-1:0] code;
  } row_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int RANDOM_ITEMS   = 1150;
  localparam longint unsigned SEC_NS = 64'h3B9ACA000000;
  // Last time value inside one second.
  localparam longint unsigned TIME_MAX = SEC_NS - 1;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [sui_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sui_pkg::CFG_DATA_W-1:0]  cfg_data;

  sui_in_if  snap();
  sui_out_if result();

  serial_unit_interval_calibrator uut (
    .clk(clk),
    .rst(rst),
    .snap(snap),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor copy of configuration and stored snapshot.
  logic [sui_pkg::RATE_W-1:0]  mdl_rate;
  logic [sui_pkg::FEC_W-1:0]   mdl_fec;
  logic [sui_pkg::SPEED_W-1:0] mdl_speed;
  logic [sui_pkg::LANES_W-1:0] mdl_lanes;
  logic [sui_pkg::TIME_W-1:0]      held_tx_time, held_rx_time;
  logic [sui_pkg::COUNT_WIDTH-1:0] held_tx_count, held_rx_count;
  logic                            held_valid;

  calib_t                       expected_calib[$];
  logic                         expected_pinned[$];
  logic [sui_pkg::STATUS_W-1:0] expected_code[$];
  int   error_count;
  int   idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hold valid or ready low for a random gap: mostly short, a few long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 200);
  endfunction

  function automatic logic [sui_pkg::TIME_W-1:0] wrap_time_delta(
      logic [sui_pkg::TIME_W-1:0] now, logic [sui_pkg::TIME_W-1:0] then_t);
    logic [sui_pkg::TIME_W:0] d;
    if (now <= then_t) d = {1'b0, now} + {1'b0, sui_pkg::ONE_SECOND} - {1'b0, then_t};
    else d = {1'b0, now} - {1'b0, then_t};
    return d[sui_pkg::TIME_W-1:0];
  endfunction

  function automatic logic [DC_W-1:0] wrap_count_delta(
      logic [sui_pkg::COUNT_WIDTH-1:0] now, logic [sui_pkg::COUNT_WIDTH-1:0] then_c);
    logic [DC_W-1:0] d;
    if (now <= then_c) d = {1'b1, {sui_pkg::COUNT_WIDTH{1'b0}}} + {1'b0, now} - {1'b0, then_c};
    else d = {1'b0, now} - {1'b0, then_c};
    return d;
  endfunction

  // Compute one UI; returns 0 when the lane-divided span is zero.
  function automatic bit path_ui(logic [sui_pkg::TIME_W-1:0] dt, logic [DC_W-1:0] dc,
                                 logic [sui_pkg::IV_W-1:0] iv, output logic [63:0] ui);
    logic [63:0] span;
    span = (64'(dc) * 64'(iv)) / 64'(mdl_lanes);
    ui = '0;
    if (span == 0) return 1'b0;
    ui = (64'(dt) << sui_pkg::UI_SHIFT) / span;
    return 1'b1;
  endfunction

  // Advance the calibrator model by one snapshot and return the result beat.
  function automatic calib_t calibrate(snap_t s);
    calib_t c;
    logic [sui_pkg::IV_W-1:0] tx_iv, rx_iv;
    logic [63:0] tx_ui, rx_ui, lo, hi;
    bit ok;
    c = '{default: '0};
    tx_ui = '0;
    rx_ui = '0;
    if (s.func == 1'b0) begin
      if (s.tx_valid && s.rx_valid) begin
        held_tx_time  = s.tx_time;
        held_rx_time  = s.rx_time;
        held_tx_count = s.tx_count[sui_pkg::COUNT_WIDTH-1:0];
        held_rx_count = s.rx_count[sui_pkg::COUNT_WIDTH-1:0];
        held_valid = 1'b1;
        c.status = sui_pkg::ST_STORED;
      end else begin
        held_valid = 1'b0;
        c.status = sui_pkg::ST_FIRST_INVALID;
      end
    end else if (!held_valid) begin
      c.status = sui_pkg::ST_NO_FIRST;
    end else begin
      held_valid = 1'b0;
      if (s.too_late) begin
        c.status = sui_pkg::ST_LATE;
      end else if (!s.tx_valid || !s.rx_valid) begin
        c.status = sui_pkg::ST_LATER_INVALID;
      end else begin
        tx_iv = '0;
        rx_iv = '0;
        case (mdl_rate)
          sui_pkg::RATE_10_25: begin
            if (mdl_fec == sui_pkg::FEC_KR) begin
              tx_iv = sui_pkg::AM_5406720; rx_iv = sui_pkg::AM_5406720;
            end else if (mdl_fec == sui_pkg::FEC_NONE) begin
              tx_iv = sui_pkg::AM_5406720; rx_iv = sui_pkg::AM_168960;
            end
          end
          sui_pkg::RATE_50: begin
            if (mdl_fec == sui_pkg::FEC_NONE) begin
              tx_iv = sui_pkg::AM_4325376; rx_iv = sui_pkg::AM_4325376;
            end else begin
              tx_iv = sui_pkg::AM_5406720; rx_iv = sui_pkg::AM_5406720;
            end
          end
          sui_pkg::RATE_40_100, sui_pkg::RATE_200: begin
            tx_iv = sui_pkg::AM_21626880; rx_iv = sui_pkg::AM_21626880;
          end
          sui_pkg::RATE_400: begin
            tx_iv = sui_pkg::AM_43253760; rx_iv = sui_pkg::AM_43253760;
          end
          default: ;
        endcase
        ok = (tx_iv != 0) && (rx_iv != 0) && (mdl_lanes != 0);
        if (ok)
          ok = path_ui(wrap_time_delta(s.tx_time, held_tx_time),
                       wrap_count_delta(s.tx_count[sui_pkg::COUNT_WIDTH-1:0], held_tx_count),
                       tx_iv, tx_ui);
        if (ok)
          ok = path_ui(wrap_time_delta(s.rx_time, held_rx_time),
                       wrap_count_delta(s.rx_count[sui_pkg::COUNT_WIDTH-1:0], held_rx_count),
                       rx_iv, rx_ui);
        if (!ok) begin
          c.status = sui_pkg::ST_NO_INTERVAL;
        end else begin
          if (mdl_speed == sui_pkg::SPEED_10G) begin
            lo = 64'(sui_pkg::UI10_MIN); hi = 64'(sui_pkg::UI10_MAX);
          end else if (mdl_speed == sui_pkg::SPEED_25G) begin
            lo = 64'(sui_pkg::UI25_MIN); hi = 64'(sui_pkg::UI25_MAX);
          end else begin
            lo = '0; hi = '0;
          end
          if (tx_ui > hi || tx_ui < lo) c.status = sui_pkg::ST_TX_RANGE;
          else if (rx_ui > hi || rx_ui < lo) c.status = sui_pkg::ST_RX_RANGE;
          else begin
            c.status = sui_pkg::ST_UPDATED;
            c.tx_ui = tx_ui[31:0];
            c.rx_ui = rx_ui[31:0];
            c.wr_en = 1'b1;
          end
        end
      end
    end
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Write one register at the falling edge; keep the model in step.
  task automatic write_reg(logic [sui_pkg::CFG_INDEX_W-1:0] idx,
                           logic [sui_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      sui_pkg::CFG_RATE:  mdl_rate  = val[sui_pkg::RATE_W-1:0];
      sui_pkg::CFG_FEC:   mdl_fec   = val[sui_pkg::FEC_W-1:0];
      sui_pkg::CFG_SPEED: mdl_speed = val[sui_pkg::SPEED_W-1:0];
      default:            mdl_lanes = val[sui_pkg::LANES_W-1:0];
    endcase
  endtask

  task automatic set_config(int rate, int fec, int speed, int lanes);
    write_reg(sui_pkg::CFG_RATE, sui_pkg::CFG_DATA_W'(rate));
    write_reg(sui_pkg::CFG_FEC, sui_pkg::CFG_DATA_W'(fec));
    write_reg(sui_pkg::CFG_SPEED, sui_pkg::CFG_DATA_W'(speed));
    write_reg(sui_pkg::CFG_LANES, sui_pkg::CFG_DATA_W'(lanes));
  endtask

  // Drop valid, hold off until every predicted beat is taken, then settle.
  task automatic wait_idle();
    snap.valid <= 1'b0;
    while (expected_calib.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Present one snapshot beat at the falling edge and hold it until taken.
  // Valid stays high after the beat; the next beat or wait_idle drops it.
  task automatic send_snap(snap_t s, logic pin, logic [sui_pkg::STATUS_W-1:0] code);
    int g;
    g = gap_len();
    if (g > 0) begin
      snap.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    snap.valid    <= 1'b1;
    snap.func     <= s.func;
    snap.tx_time  <= s.tx_time;
    snap.tx_count <= s.tx_count;
    snap.tx_valid <= s.tx_valid;
    snap.rx_time  <= s.rx_time;
    snap.rx_count <= s.rx_count;
    snap.rx_valid <= s.rx_valid;
    snap.too_late <= s.too_late;
    do @(posedge clk); while (!snap.ready);
    expected_calib.push_back(calibrate(s));
    expected_pinned.push_back(pin);
    expected_code.push_back(code);
    @(negedge clk);
  endtask

  function automatic logic [sui_pkg::TIME_W-1:0] rand_time();
    logic [63:0] t;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return sui_pkg::TIME_W'(TIME_MAX);
    if (r == 2) return {sui_pkg::TIME_W{1'b1}};
    t = {$urandom, $urandom};
    return t[sui_pkg::TIME_W-1:0];
  endfunction

  function automatic snap_t rand_snap();
    snap_t s;
    s.func     = 1'($urandom_range(0, 1));
    s.tx_time  = rand_time();
    s.rx_time  = rand_time();
    s.tx_count = sui_pkg::COUNT_IN_W'($urandom);
    s.rx_count = sui_pkg::COUNT_IN_W'($urandom);
    s.tx_valid = ($urandom_range(0, 7) != 0);
    s.rx_valid = ($urandom_range(0, 7) != 0);
    s.too_late = ($urandom_range(0, 7) == 0);
    return s;
  endfunction

  // A well-formed pair whose later snapshot lands near the nominal UI.
  task automatic send_pair();
    snap_t a, b;
    logic [63:0] ui_tgt, span, dt;
    logic [DC_W-1:0] dc;
    logic [sui_pkg::IV_W-1:0] iv;
    a = rand_snap();
    a.func = 1'b0;
    a.tx_valid = 1'b1;
    a.rx_valid = 1'b1;
    a.tx_time = sui_pkg::TIME_W'({$urandom, $urandom} % SEC_NS);
    a.rx_time = sui_pkg::TIME_W'({$urandom, $urandom} % SEC_NS);
    send_snap(a, 1'b0, '0);
    b = a;
    b.func = 1'b1;
    b.too_late = ($urandom_range(0, 15) == 0);
    b.tx_valid = ($urandom_range(0, 15) != 0);
    b.rx_valid = ($urandom_range(0, 15) != 0);
    ui_tgt = (mdl_speed == sui_pkg::SPEED_25G) ? 64'h9EE000 : 64'h18D3000;
    ui_tgt = ui_tgt + 64'($urandom_range(0, 8000)) - 64'd4000;
    iv = (mdl_rate == sui_pkg::RATE_400) ? sui_pkg::AM_43253760 :
         (mdl_rate >= sui_pkg::RATE_40_100) ? sui_pkg::AM_21626880 : sui_pkg::AM_5406720;
    dc = DC_W'($urandom_range(1, 3));
    span = (64'(dc) * 64'(iv)) / ((mdl_lanes == 0) ? 64'd1 : 64'(mdl_lanes));
    dt = (span * ui_tgt) >> sui_pkg::UI_SHIFT;
    b.tx_count = a.tx_count + sui_pkg::COUNT_IN_W'(dc);
    b.rx_count = a.rx_count + sui_pkg::COUNT_IN_W'(dc);
    b.tx_time = sui_pkg::TIME_W'((64'(a.tx_time) + dt) % SEC_NS);
    b.rx_time = sui_pkg::TIME_W'((64'(a.rx_time) + dt + 64'($urandom_range(0, 3))) % SEC_NS);
    send_snap(b, 1'b0, '0);
  endtask

  // Result side: random ready, compare each taken beat with the oldest entry.
  initial begin
    calib_t want;
    logic   pin;
    logic [sui_pkg::STATUS_W-1:0] code;
    int g;
    result.ready = 1'b0;
    @(negedge clk);
    forever begin
      g = gap_len();
      if (g > 0) begin
        result.ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      result.ready <= 1'b1;
      @(posedge clk);
      if (result.valid && result.ready) begin
        if (expected_calib.size() == 0) begin
          report_mismatch("unexpected beat", 64'(result.status), 64'd0);
        end else begin
          want = expected_calib.pop_front();
          pin  = expected_pinned.pop_front();
          code = expected_code.pop_front();
          if (pin && want.status != code)
            report_mismatch("table status", 64'(want.status), 64'(code));
          if (result.status !== want.status)
            report_mismatch("status", 64'(result.status), 64'(want.status));
          if (result.tx_unit_interval !== want.tx_ui)
            report_mismatch("tx_unit_interval", 64'(result.tx_unit_interval),
                            64'(want.tx_ui));
          if (result.rx_unit_interval !== want.rx_ui)
            report_mismatch("rx_unit_interval", 64'(result.rx_unit_interval),
                            64'(want.rx_ui));
          if (result.write_enable !== want.wr_en)
            report_mismatch("write_enable", 64'(result.write_enable), 64'(want.wr_en));
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog: count cycles in which no beat moves on either channel.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((snap.valid && snap.ready) || (result.valid && result.ready) || rst)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stimulus: reset, directed table, a zero-lanes check, then random phases over several settings.
  initial begin
    row_t dir_rows[$];
    snap_t s;
    int n, k;
    error_count = 0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    snap.valid = 1'b0;
    snap.func = 1'b0;
    snap.tx_time = '0;
    snap.tx_count = '0;
    snap.tx_valid = 1'b0;
    snap.rx_time = '0;
    snap.rx_count = '0;
    snap.rx_valid = 1'b0;
    snap.too_late = 1'b0;
    mdl_rate = sui_pkg::RATE_10_25;
    mdl_fec = sui_pkg::FEC_KR;
    mdl_speed = sui_pkg::SPEED_10G;
    mdl_lanes = sui_pkg::LANES_W'(1);
    held_valid = 1'b0;
    held_tx_time = '0;
    held_rx_time = '0;
    held_tx_count = '0;
    held_rx_count = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: pairing right after reset finds nothing stored, then
    // invalid first snapshots, late and invalid later ones, equal snapshots
    // (full wrap), extreme times and counts.
    dir_rows = '{
      '{'{1'b1, '0, '0, 1'b1, '0, '0, 1'b1, 1'b0}, 1'b1, sui_pkg::ST_NO_FIRST},
      '{'{1'b0, '0, '0, 1'b0, '0, '0, 1'b1, 1'b0}, 1'b1, sui_pkg::ST_FIRST_INVALID},
      '{'{1'b1, '0, '0, 1'b1, '0, '0, 1'b1, 1'b0}, 1'b1, sui_pkg::ST_NO_FIRST},
      '{'{1'b0, '0, '0, 1'b1, '0, '0, 1'b0, 1'b0}, 1'b1, sui_pkg::ST_FIRST_INVALID},
      '{'{1'b0, '0, '0, 1'b1, '0, '0, 1'b1, 1'b0}, 1'b1, sui_pkg::ST_STORED},
      '{'{1'b1, '0, '0, 1'b1, '0, '0, 1'b1, 1'b1}, 1'b1, sui_pkg::ST_LATE},
      '{'{1'b1, '0, '0, 1'b1, '0, '0, 1'b1, 1'b0}, 1'b1, sui_pkg::ST_NO_FIRST},
      '{'{1'b0, 46'h3B9ACA000000 - 46'd1, 15'h7FFF, 1'b1, '1, 15'h7FFF, 1'b1, 1'b0},
        1'b1, sui_pkg::ST_STORED},
      '{'{1'b1, '0, '0, 1'b0, '0, '0, 1'b1, 1'b0}, 1'b1, sui_pkg::ST_LATER_INVALID},
      '{'{1'b0, 46'h1000, 15'd10, 1'b1, 46'h1000, 15'd10, 1'b1, 1'b0},
        1'b1, sui_pkg::ST_STORED},
      '{'{1'b1, 46'h1000, 15'd10, 1'b1, 46'h1000, 15'd10, 1'b1, 1'b0}, 1'b0, '0},
      '{'{1'b0, '1, '0, 1'b1, '0, '1, 1'b1, 1'b0}, 1'b1, sui_pkg::ST_STORED},
      '{'{1'b1, '0, '1, 1'b1, '1, '0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{1'b0, 46'h0, 15'd0, 1'b1, 46'h0, 15'd0, 1'b1, 1'b0}, 1'b1, sui_pkg::ST_STORED},
      '{'{1'b1, 46'h5A0000, 15'd1, 1'b1, 46'h5A0000, 15'd1, 1'b1, 1'b0}, 1'b0, '0},
      '{'{1'b0, 46'h0, 15'd0, 1'b1, 46'h0, 15'd0, 1'b1, 1'b0}, 1'b1, sui_pkg::ST_STORED},
      '{'{1'b1, 46'h0, 15'd0, 1'b1, 46'h0, 15'd0, 1'b1, 1'b0}, 1'b0, '0}
    };
    foreach (dir_rows[i])
      send_snap(dir_rows[i].s, dir_rows[i].check_code, dir_rows[i].code);
    wait_idle();

    // Zero lanes leaves no interval.
    set_config(32'(sui_pkg::RATE_10_25), 32'(sui_pkg::FEC_KR), 32'(sui_pkg::SPEED_10G), 0);
    send_snap('{1'b0, 46'h0, 15'd0, 1'b1, 46'h0, 15'd0, 1'b1, 1'b0}, 1'b1,
              sui_pkg::ST_STORED);
    send_snap('{1'b1, 46'h100, 15'd1, 1'b1, 46'h100, 15'd1, 1'b1, 1'b0}, 1'b1,
              sui_pkg::ST_NO_INTERVAL);
    wait_idle();

    // Random phases, each with a fresh setting; extremes come first.
    n = 0;
    k = 0;
    while (n < RANDOM_ITEMS) begin
      case (k)
        0: set_config(32'(sui_pkg::RATE_10_25), 32'(sui_pkg::FEC_KR),
                      32'(sui_pkg::SPEED_10G), 1);
        1: set_config(7, 3, 3, 31);
        2: set_config(32'(sui_pkg::RATE_400), 32'(sui_pkg::FEC_NONE),
                      32'(sui_pkg::SPEED_25G), 16);
        3: set_config(32'(sui_pkg::RATE_10_25), 32'(sui_pkg::FEC_NONE),
                      32'(sui_pkg::SPEED_10G), 1);
        default: set_config($urandom_range(0, 7), $urandom_range(0, 3),
                            $urandom_range(0, 3), $urandom_range(0, 31));
      endcase
      if ($urandom_range(0, 3) == 0)
        set_config($urandom_range(0, 4), $urandom_range(0, 2),
                   $urandom_range(0, 1), $urandom_range(1, 16));
      repeat (50) begin
        if ($urandom_range(0, 3) != 0) begin
          send_pair();
          n += 2;
        end else begin
          s = rand_snap();
          send_snap(s, 1'b0, '0);
          n++;
        end
      end
      wait_idle();
      k++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && expected_calib.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
